// ----- rtl/rtpfua_pkg.sv -----
// ----------------------------------------------------------------------------
// RTP FU-A packetizer package
// Shared types, constants and register indexes for the H.264 RTP packetizer.
// ----------------------------------------------------------------------------
package rtpfua_pkg;

  localparam int SIZE_BITS   = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int POS_W       = 4;

  localparam logic [1:0] CFG_PAYLOAD_TYPE = 2'd0;
  localparam logic [1:0] CFG_SSRC_VALUE   = 2'd1;
  localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd2;

  localparam logic [6:0]  PAYLOAD_TYPE_RESET = 7'd96;
  localparam logic [31:0] SSRC_VALUE_RESET   = 32'd0;
  localparam logic [10:0] MAX_PAYLOAD_RESET  = 11'd1488;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] NRI_MASK         = 8'h60;
  localparam logic [4:0] FU_A_TYPE        = 5'd28;
  localparam logic [4:0] NAL_TYPE_SPS     = 5'd7;
  localparam logic [4:0] NAL_TYPE_PPS     = 5'd8;

  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_SINGLE = 2'd1;
  localparam logic [1:0] CMD_FRAG   = 2'd2;

  localparam logic [POS_W-1:0] LAST_POS_BYTE   = 4'd0;
  localparam logic [POS_W-1:0] LAST_POS_SINGLE = 4'd12;
  localparam logic [POS_W-1:0] LAST_POS_FRAG   = 4'd14;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        nal_start;
    logic [23:0] nal_size;
    logic [31:0] timestamp;
    logic        frame_end;
  } nal_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_start;
    logic       packet_end;
    logic       run_last;
  } rtp_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        pend;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
  } cmd_t;

endpackage

// ----- rtl/rtpfua_front.sv -----
// ----------------------------------------------------------------------------
// RTP FU-A packetizer front end
// Accepts NAL bytes, tracks the NAL and fragment state and queues one
// command for every byte that produces packet output.
// ----------------------------------------------------------------------------
module rtpfua_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  nal_valid,
  output logic                  nal_stall,
  input  rtpfua_pkg::nal_item_t nal_item,
  input  logic [10:0]           max_payload,
  input  logic                  full,
  output logic                  push,
  output rtpfua_pkg::cmd_t      cmd
);

  localparam int SB = rtpfua_pkg::SIZE_BITS;

  logic [15:0]   seq_number;
  logic [SB-1:0] byte_index;
  logic [SB-1:0] nal_length;
  logic [7:0]    nal_header_byte;
  logic          drop_flag;
  logic          fragment_mode;
  logic [10:0]   fragment_left;
  logic          first_fragment;
  logic [31:0]   held_timestamp;
  logic          held_marker;

  logic [15:0]   seq_number_next;
  logic [SB-1:0] idx;
  logic [SB-1:0] len;
  logic [7:0]    hdr_next;
  logic          drop;
  logic          frag;
  logic [10:0]   fleft;
  logic [10:0]   fl;
  logic          first;
  logic [31:0]   stamp;
  logic          mark;
  logic          accept;
  logic          in_range;
  logic          active;
  logic          last;
  logic [SB-1:0] left_now;
  logic [10:0]   chunk;

  assign nal_stall = full;
  assign accept    = nal_valid && !full;

  always_comb begin
    len   = nal_length;
    drop  = drop_flag;
    frag  = fragment_mode;
    fleft = fragment_left;
    first = first_fragment;
    stamp = held_timestamp;
    mark  = held_marker;
    idx   = (&byte_index) ? byte_index : byte_index + SB'(1);
    if (nal_item.nal_start) begin
      len   = SB'(nal_item.nal_size);
      drop  = len < SB'(5);
      frag  = !drop && ((len - SB'(3)) > SB'(max_payload));
      fleft = '0;
      first = 1'b1;
      stamp = nal_item.timestamp;
      mark  = nal_item.frame_end;
      idx   = '0;
    end
    in_range = idx < len;
    left_now = len - idx;
    active   = (idx >= SB'(3)) && in_range && !drop;
    chunk    = (max_payload > 11'd2) ? max_payload - 11'd2 : 11'd1;
    last     = left_now <= SB'(chunk);
    hdr_next = nal_header_byte;
    seq_number_next = seq_number;
    fl   = fleft;
    push = 1'b0;

    cmd.kind   = rtpfua_pkg::CMD_BYTE;
    cmd.data   = nal_item.data_byte;
    cmd.pend   = left_now == SB'(1);
    cmd.marker = mark;
    cmd.seq    = seq_number;
    cmd.stamp  = stamp;
    cmd.fu_ind = (nal_header_byte & rtpfua_pkg::NRI_MASK) | {3'b000, rtpfua_pkg::FU_A_TYPE};
    cmd.fu_hdr = {first, last, 1'b0, nal_header_byte[4:0]};

    if (active) begin
      if (idx == SB'(3)) begin
        hdr_next = nal_item.data_byte;
        if (nal_item.data_byte[4:0] == rtpfua_pkg::NAL_TYPE_SPS ||
            nal_item.data_byte[4:0] == rtpfua_pkg::NAL_TYPE_PPS) begin
          drop = 1'b1;
        end else if (!frag) begin
          push            = 1'b1;
          cmd.kind        = rtpfua_pkg::CMD_SINGLE;
          seq_number_next = seq_number + 16'd1;
        end
      end else if (!frag) begin
        push = 1'b1;
      end else begin
        push = 1'b1;
        if (fleft == 11'd0) begin
          cmd.kind        = rtpfua_pkg::CMD_FRAG;
          cmd.marker      = mark && last;
          fl              = last ? left_now[10:0] : chunk;
          first           = 1'b0;
          seq_number_next = seq_number + 16'd1;
        end
        fleft    = fl - 11'd1;
        cmd.pend = fl == 11'd1;
      end
    end
    push = push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_number      <= '0;
      byte_index      <= '0;
      nal_length      <= '0;
      nal_header_byte <= '0;
      drop_flag       <= 1'b0;
      fragment_mode   <= 1'b0;
      fragment_left   <= '0;
      first_fragment  <= 1'b1;
      held_timestamp  <= '0;
      held_marker     <= 1'b0;
    end else if (accept) begin
      seq_number      <= seq_number_next;
      byte_index      <= idx;
      nal_length      <= len;
      nal_header_byte <= hdr_next;
      drop_flag       <= drop;
      fragment_mode   <= frag;
      fragment_left   <= fleft;
      first_fragment  <= first;
      held_timestamp  <= stamp;
      held_marker     <= mark;
    end
  end

endmodule

// ----- rtl/rtpfua_queue.sv -----
// ----------------------------------------------------------------------------
// RTP FU-A packetizer command queue
// A short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module rtpfua_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rtpfua_pkg::cmd_t wr_cmd,
  input  logic             pop,
  output rtpfua_pkg::cmd_t head,
  output logic             empty,
  output logic             full
);

  localparam int QW = rtpfua_pkg::QPTR_W;

  rtpfua_pkg::cmd_t entries [rtpfua_pkg::QUEUE_DEPTH];
  logic [QW-1:0]    wr_ptr;
  logic [QW-1:0]    rd_ptr;
  logic [QW:0]      count;

  assign head  = entries[rd_ptr];
  assign empty = count == '0;
  assign full  = count == (QW + 1)'(rtpfua_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QW + 1)'(1);
        2'b01:   count <= count - (QW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  // A push into a full queue or a pop from an empty one would lose or invent a request.
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from an empty queue");

endmodule

// ----- rtl/rtpfua_back.sv -----
// ----------------------------------------------------------------------------
// RTP FU-A packetizer back end
// Expands each command into RTP header, FU bytes and payload byte as its kind needs,
// one byte per cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module rtpfua_back (
  input  logic                  clk,
  input  logic                  rst,
  input  rtpfua_pkg::cmd_t      head,
  input  logic                  empty,
  output logic                  pop,
  input  logic [6:0]            payload_type,
  input  logic [31:0]           ssrc_value,
  output logic                  rtp_valid,
  input  logic                  rtp_stall,
  output rtpfua_pkg::rtp_item_t rtp_item
);

  localparam int PW = rtpfua_pkg::POS_W;

  logic [PW-1:0]         pos;
  logic [PW-1:0]         pos_next;
  logic [PW-1:0]         last_pos;
  logic                  advance;
  logic                  is_last;
  rtpfua_pkg::rtp_item_t item_next;

  assign advance = !rtp_valid || !rtp_stall;

  always_comb begin
    case (head.kind)
      rtpfua_pkg::CMD_SINGLE: last_pos = rtpfua_pkg::LAST_POS_SINGLE;
      rtpfua_pkg::CMD_FRAG:   last_pos = rtpfua_pkg::LAST_POS_FRAG;
      default:                last_pos = rtpfua_pkg::LAST_POS_BYTE;
    endcase
    is_last = pos == last_pos;
    pop      = advance && !empty && is_last;
    pos_next = is_last ? '0 : pos + PW'(1);

    item_next.packet_start = (pos == '0) && (head.kind != rtpfua_pkg::CMD_BYTE);
    item_next.packet_end   = is_last && head.pend;
    item_next.run_last     = is_last;
    if (is_last) begin
      item_next.out_byte = head.data;
    end else begin
      case (pos)
        4'd0:    item_next.out_byte = rtpfua_pkg::RTP_VERSION_BYTE;
        4'd1:    item_next.out_byte = {head.marker, payload_type};
        4'd2:    item_next.out_byte = head.seq[15:8];
        4'd3:    item_next.out_byte = head.seq[7:0];
        4'd4:    item_next.out_byte = head.stamp[31:24];
        4'd5:    item_next.out_byte = head.stamp[23:16];
        4'd6:    item_next.out_byte = head.stamp[15:8];
        4'd7:    item_next.out_byte = head.stamp[7:0];
        4'd8:    item_next.out_byte = ssrc_value[31:24];
        4'd9:    item_next.out_byte = ssrc_value[23:16];
        4'd10:   item_next.out_byte = ssrc_value[15:8];
        4'd11:   item_next.out_byte = ssrc_value[7:0];
        4'd12:   item_next.out_byte = head.fu_ind;
        4'd13:   item_next.out_byte = head.fu_hdr;
        default: item_next.out_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rtp_valid <= 1'b0;
      pos       <= '0;
    end else if (advance) begin
      rtp_valid <= !empty;
      if (!empty) begin
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !empty) begin
      rtp_item <= item_next;
    end
  end

  // Mid-packet the request being expanded must still sit at the head of the queue.
  assert property (@(posedge clk) disable iff (rst) (pos != '0) |-> !empty)
    else $error("packet expansion lost its request");
  // Every packet is at least thirteen bytes, so a packet never starts on a request's last byte.
  assert property (@(posedge clk) disable iff (rst)
      (rtp_valid && rtp_item.packet_start) |-> !rtp_item.run_last)
    else $error("packet start on the last byte of a request");
  assert property (@(posedge clk) disable iff (rst) pos <= rtpfua_pkg::LAST_POS_FRAG)
    else $error("byte position beyond the longest request");

endmodule

// ----- rtl/h264_rtp_fua_packetizer.sv -----
// ----------------------------------------------------------------------------
// H.264 RTP FU-A packetizer
// An accepted input byte that produces output is written into the command
// queue, then expanded into the registered output stage. Throughput: one
// input byte per cycle for payload bytes while the four-entry queue is not
// full; each packet header adds 12 output bytes, 14 for an FU-A fragment.
// Reset: synchronous; state and queue cleared, registers to their defaults.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  nal_valid,
  output logic                  nal_stall,
  input  rtpfua_pkg::nal_item_t nal_item,
  output logic                  rtp_valid,
  input  logic                  rtp_stall,
  output rtpfua_pkg::rtp_item_t rtp_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  logic [6:0]       payload_type;
  logic [31:0]      ssrc_value;
  logic [10:0]      max_payload;
  logic             push;
  logic             pop;
  logic             empty;
  logic             full;
  rtpfua_pkg::cmd_t wr_cmd;
  rtpfua_pkg::cmd_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_type <= rtpfua_pkg::PAYLOAD_TYPE_RESET;
      ssrc_value   <= rtpfua_pkg::SSRC_VALUE_RESET;
      max_payload  <= rtpfua_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtpfua_pkg::CFG_PAYLOAD_TYPE: payload_type <= cfg_data[6:0];
        rtpfua_pkg::CFG_SSRC_VALUE:   ssrc_value   <= cfg_data;
        rtpfua_pkg::CFG_MAX_PAYLOAD:  max_payload  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  rtpfua_front u_front (
    .clk         (clk),
    .rst         (rst),
    .nal_valid   (nal_valid),
    .nal_stall   (nal_stall),
    .nal_item    (nal_item),
    .max_payload (max_payload),
    .full        (full),
    .push        (push),
    .cmd         (wr_cmd)
  );

  rtpfua_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  rtpfua_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .payload_type (payload_type),
    .ssrc_value   (ssrc_value),
    .rtp_valid    (rtp_valid),
    .rtp_stall    (rtp_stall),
    .rtp_item     (rtp_item)
  );

endmodule
